[sv/clcd_pkg.sv]
package clcd_pkg;

    // Field widths
    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int LINE_W  = 2;
    localparam int COL_W   = 6;
    localparam int NIB_W   = 4;
    localparam int CFG_W   = 16;
    localparam int HOLD_W  = 17;
    localparam int NIDX_W  = 4;   // nibble index, up to 12 nibbles for init
    localparam int STEP_W  = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSTR   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DATA    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_POS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CHAR_AT = 3'd4;

    // Pin step codes within one nibble transfer
    localparam logic [STEP_W-1:0] STEP_NIB   = 2'd0;
    localparam logic [STEP_W-1:0] STEP_RS    = 2'd1;
    localparam logic [STEP_W-1:0] STEP_EN_HI = 2'd2;
    localparam logic [STEP_W-1:0] STEP_EN_LO = 2'd3;

    // Configuration register indexes
    localparam logic REG_STEP_HOLD = 1'b0;
    localparam logic REG_BUSY_HOLD = 1'b1;

    localparam logic [CFG_W-1:0] STEP_HOLD_RESET = 16'd1005;
    localparam logic [CFG_W-1:0] BUSY_HOLD_RESET = 16'd12750;

    localparam logic [BYTE_W-1:0] SET_DDRAM = 8'h80;

    // One pin step handed from sequencer to pin unit
    typedef struct packed {
        logic              issue;
        logic [STEP_W-1:0] step;
        logic [NIB_W-1:0]  nib;
        logic              rs;
        logic              busy_add;
        logic              last;
    } step_req_t;

    typedef struct packed {
        logic [NIB_W-1:0] nib;
        logic             rs;
        logic             busy;
    } nib_info_t;

    function automatic logic [BYTE_W-1:0] line_offset(input logic [LINE_W-1:0] ln);
        logic [BYTE_W-1:0] r;
        begin
            case (ln)
                2'd0:    r = 8'h00;
                2'd1:    r = 8'h40;
                2'd2:    r = 8'h14;
                2'd3:    r = 8'h54;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

    function automatic logic [BYTE_W-1:0] init_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] r;
        begin
            case (idx)
                2'd0:    r = 8'h28;
                2'd1:    r = 8'h0C;
                2'd2:    r = 8'h01;
                2'd3:    r = 8'h06;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

    // Index of the final nibble of each command
    function automatic logic [NIDX_W-1:0] last_nib(input logic [CMD_W-1:0] cmd);
        logic [NIDX_W-1:0] r;
        begin
            case (cmd)
                CMD_INIT:    r = 4'd11;
                CMD_CHAR_AT: r = 4'd3;
                default:     r = 4'd1;
            endcase
            return r;
        end
    endfunction

    // Nibble value, register select and busy wait of nibble k of a command
    function automatic nib_info_t nibble_info(
        input logic [CMD_W-1:0]  cmd,
        input logic [NIDX_W-1:0] k,
        input logic [BYTE_W-1:0] val,
        input logic [BYTE_W-1:0] pos
    );
        nib_info_t         r;
        logic [NIDX_W-1:0] j;
        logic [BYTE_W-1:0] b;
        begin
            j = k - 4'd4;
            b = val;
            r.rs   = 1'b0;
            r.busy = k[0];
            case (cmd)
                CMD_INIT:    b = init_byte(j[2:1]);
                CMD_INSTR:   b = val;
                CMD_DATA:
                begin
                    b    = val;
                    r.rs = 1'b1;
                end
                CMD_SET_POS: b = pos;
                CMD_CHAR_AT:
                begin
                    b    = k[1] ? val : pos;
                    r.rs = k[1];
                end
                default:     b = val;
            endcase
            r.nib = k[0] ? b[3:0] : b[7:4];
            // raw wake-up nibbles 3,3,3,2 lead the init sequence
            if (cmd == CMD_INIT && k < 4'd4)
            begin
                r.nib  = (k == 4'd3) ? 4'h2 : 4'h3;
                r.busy = 1'b0;
            end
            return r;
        end
    endfunction

endpackage

[sv/char_lcd_nibble_write_sequencer.sv]
// Channel | Handshake           | Payload
// --------+---------------------+-----------------------------------------------
// in      | in_valid/in_ready   | command, byte_value, line, column
// out     | out_valid/out_ready | data_nibble, reg_select, enable_pin,
//         |                     | hold_units, last
// cfg     | cfg_we (no wait)    | cfg_index, cfg_data
//
// One pin step per cycle from the nibble/step counter into the output register:
// 8 steps for a byte command, 16 for character at position, 48 for init. Output
// stalls hold the counter in place. A new command is taken once the final step has
// entered the output register, even while that step still waits to be taken.
// Unused codes are dropped.
// Reset: pin levels zero, step_hold 1005, busy_hold 12750, no clearing pass.
module char_lcd_nibble_write_sequencer
    import clcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  command,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic [LINE_W-1:0] line,
    input  logic [COL_W-1:0]  column,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [NIB_W-1:0]  data_nibble,
    output logic              reg_select,
    output logic              enable_pin,
    output logic [HOLD_W-1:0] hold_units,
    output logic              last,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    step_req_t req;
    logic      slot_free;

    // Command sequencer
    clcd_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .byte_value (byte_value),
        .line       (line),
        .column     (column),
        .slot_free  (slot_free),
        .req        (req)
    );

    // Pin levels, hold adder and output register
    clcd_pin u_pin (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req         (req),
        .slot_free   (slot_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_nibble (data_nibble),
        .reg_select  (reg_select),
        .enable_pin  (enable_pin),
        .hold_units  (hold_units),
        .last        (last)
    );

endmodule

[sv/clcd_seq.sv]
module clcd_seq
    import clcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  command,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic [LINE_W-1:0] line,
    input  logic [COL_W-1:0]  column,
    input  logic              slot_free,
    output step_req_t         req
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [BYTE_W-1:0] val_reg, val_next;
    logic [BYTE_W-1:0] pos_reg, pos_next;
    logic [NIDX_W-1:0] nib_reg, nib_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic      accept;
    logic      is_last_nib;
    nib_info_t info;

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign is_last_nib = (nib_reg == last_nib(cmd_reg));
    assign info        = nibble_info(cmd_reg, nib_reg, val_reg, pos_reg);

    // Step descriptor for the pin unit
    always_comb
    begin
        req.issue    = (state_reg == ST_RUN) && slot_free;
        req.step     = step_reg;
        req.nib      = info.nib;
        req.rs       = info.rs;
        req.busy_add = info.busy && (step_reg == STEP_EN_LO);
        req.last     = is_last_nib && (step_reg == STEP_EN_LO);
    end

    // Nibble/step counter
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        val_next   = val_reg;
        pos_next   = pos_reg;
        nib_next   = nib_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && command <= CMD_CHAR_AT)
                begin
                    state_next = ST_RUN;
                    cmd_next   = command;
                    val_next   = byte_value;
                    pos_next   = SET_DDRAM | (line_offset(line) + {2'b00, column});
                    nib_next   = '0;
                    step_next  = STEP_NIB;
                end
            end
            ST_RUN:
            begin
                if (req.issue)
                begin
                    step_next = step_reg + 2'd1;
                    if (step_reg == STEP_EN_LO)
                    begin
                        if (is_last_nib)
                            state_next = ST_IDLE;
                        else
                            nib_next = nib_reg + 4'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nib_reg   <= '0;
            step_reg  <= STEP_NIB;
        end
        else
        begin
            state_reg <= state_next;
            nib_reg   <= nib_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        val_reg <= val_next;
        pos_reg <= pos_next;
    end

    // Checks
    a_nib_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (nib_reg <= last_nib(cmd_reg)))
        else $error("nibble index past end of command");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.issue && req.last) |=> (state_reg == ST_IDLE))
        else $error("sequencer kept running after final step");

    a_nib_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (req.issue && step_reg == STEP_EN_LO && !req.last)
        |=> (nib_reg == $past(nib_reg) + 4'd1 && step_reg == STEP_NIB))
        else $error("nibble index did not advance");

    a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && !slot_free) |=> $stable(step_reg) && $stable(nib_reg))
        else $error("step moved while output stalled");

endmodule

[sv/clcd_pin.sv]
module clcd_pin
    import clcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  step_req_t         req,
    output logic              slot_free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [NIB_W-1:0]  data_nibble,
    output logic              reg_select,
    output logic              enable_pin,
    output logic [HOLD_W-1:0] hold_units,
    output logic              last
);

    logic [CFG_W-1:0]  step_hold_reg;
    logic [CFG_W-1:0]  busy_hold_reg;
    logic [NIB_W-1:0]  nibble_level_reg, nibble_level_next;
    logic              select_level_reg, select_level_next;
    logic              strobe_level_reg, strobe_level_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic              last_reg;
    logic              out_valid_reg, out_valid_next;

    assign slot_free = !out_valid_reg || out_ready;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_hold_reg <= STEP_HOLD_RESET;
            busy_hold_reg <= BUSY_HOLD_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_STEP_HOLD)
                step_hold_reg <= cfg_data;
            else
                busy_hold_reg <= cfg_data;
        end
    end

    // Pin level update for the issued step
    always_comb
    begin
        nibble_level_next = nibble_level_reg;
        select_level_next = select_level_reg;
        strobe_level_next = strobe_level_reg;
        case (req.step)
            STEP_NIB:    nibble_level_next = req.nib;
            STEP_RS:     select_level_next = req.rs;
            STEP_EN_HI:  strobe_level_next = 1'b1;
            STEP_EN_LO:  strobe_level_next = 1'b0;
            default:     strobe_level_next = strobe_level_reg;
        endcase
    end

    // Hold adder: step hold plus busy wait on a byte's final step
    assign hold_next = {1'b0, step_hold_reg}
                     + {1'b0, (req.busy_add ? busy_hold_reg : {CFG_W{1'b0}})};

    assign out_valid_next = req.issue ? 1'b1 : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nibble_level_reg <= '0;
            select_level_reg <= 1'b0;
            strobe_level_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (req.issue)
            begin
                nibble_level_reg <= nibble_level_next;
                select_level_reg <= select_level_next;
                strobe_level_reg <= strobe_level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.issue)
        begin
            hold_reg <= hold_next;
            last_reg <= req.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_nibble = nibble_level_reg;
    assign reg_select  = select_level_reg;
    assign enable_pin  = strobe_level_reg;
    assign hold_units  = hold_reg;
    assign last        = last_reg;

endmodule

[bench/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import clcd_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int QUIET_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 60;
    localparam int ITEMS_PER_PHASE = 36;

    // Command codes the block drops without any pin activity
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    localparam logic [CFG_W-1:0] HOLD_MAX = '1;
    localparam logic [CFG_W-1:0] HOLD_MIN = '0;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] val;
        logic [LINE_W-1:0] ln;
        logic [COL_W-1:0]  col;
    } lcd_cmd_t;

    typedef struct {
        logic [NIB_W-1:0]  nib;
        logic              rs;
        logic              en;
        logic [HOLD_W-1:0] hold;
        logic              fin;
    } pin_step_t;

    // Expands commands into pin steps and checks the block's steps in order
    class pin_step_ledger;
        pin_step_t        expected_steps[$];
        logic [CFG_W-1:0] step_hold;
        logic [CFG_W-1:0] busy_hold;
        logic [NIB_W-1:0] nib_level;
        logic             rs_level;
        logic             en_level;
        int               failures;

        function new();
            step_hold = STEP_HOLD_RESET;
            busy_hold = BUSY_HOLD_RESET;
            nib_level = '0;
            rs_level  = 1'b0;
            en_level  = 1'b0;
            failures  = 0;
        endfunction

        function void set_reg(logic idx, logic [CFG_W-1:0] v);
            if (idx == REG_STEP_HOLD)
                step_hold = v;
            else
                busy_hold = v;
        endfunction

        // Pin levels after one change, held for step_hold plus any busy wait
        function void push_step(logic [CFG_W-1:0] extra);
            pin_step_t s;
            s.nib  = nib_level;
            s.rs   = rs_level;
            s.en   = en_level;
            s.hold = {1'b0, step_hold} + {1'b0, extra};
            s.fin  = 1'b0;
            expected_steps.push_back(s);
        endfunction

        function void send_nibble(logic [NIB_W-1:0] nib, logic rs, logic [CFG_W-1:0] extra);
            nib_level = nib;
            push_step(HOLD_MIN);
            rs_level = rs;
            push_step(HOLD_MIN);
            en_level = 1'b1;
            push_step(HOLD_MIN);
            en_level = 1'b0;
            push_step(extra);
        endfunction

        function void send_byte(logic [BYTE_W-1:0] b, logic rs);
            send_nibble(b[7:4], rs, HOLD_MIN);
            send_nibble(b[3:0], rs, busy_hold);
        endfunction

        // DDRAM address: row base plus column, wrapped to eight bits
        function logic [BYTE_W-1:0] position_byte(logic [LINE_W-1:0] ln, logic [COL_W-1:0] col);
            logic [BYTE_W-1:0] base;
            case (ln)
                2'd1:    base = 8'h40;
                2'd2:    base = 8'h14;
                2'd3:    base = 8'h54;
                default: base = 8'h00;
            endcase
            return SET_DDRAM | (base + {2'b00, col});
        endfunction

        function void note_command(lcd_cmd_t c);
            logic [BYTE_W-1:0] setup [4];
            logic [BYTE_W-1:0] pos;
            int                start_n;
            pin_step_t         tail;
            setup   = '{8'h28, 8'h0C, 8'h01, 8'h06};
            pos     = position_byte(c.ln, c.col);
            start_n = expected_steps.size();
            case (c.cmd)
                CMD_INIT:
                begin
                    // wake-up nibbles 3,3,3,2 carry no busy wait
                    for (int i = 0; i < 4; i++)
                        send_nibble((i == 3) ? 4'h2 : 4'h3, 1'b0, HOLD_MIN);
                    foreach (setup[i])
                        send_byte(setup[i], 1'b0);
                end
                CMD_INSTR:   send_byte(c.val, 1'b0);
                CMD_DATA:    send_byte(c.val, 1'b1);
                CMD_SET_POS: send_byte(pos, 1'b0);
                CMD_CHAR_AT:
                begin
                    send_byte(pos, 1'b0);
                    send_byte(c.val, 1'b1);
                end
                default: ;
            endcase
            if (expected_steps.size() > start_n)
            begin
                tail = expected_steps.pop_back();
                tail.fin = 1'b1;
                expected_steps.push_back(tail);
            end
        endfunction

        function void check_step(pin_step_t got);
            pin_step_t want;
            if (expected_steps.size() == 0)
            begin
                $error("unexpected pin step: nibble %0h rs %0b en %0b hold %0d last %0b",
                       got.nib, got.rs, got.en, got.hold, got.fin);
                failures++;
                return;
            end
            want = expected_steps.pop_front();
            if (got.nib !== want.nib)
            begin
                $error("data_nibble: expected %0h, actual %0h", want.nib, got.nib);
                failures++;
            end
            if (got.rs !== want.rs)
            begin
                $error("reg_select: expected %0b, actual %0b", want.rs, got.rs);
                failures++;
            end
            if (got.en !== want.en)
            begin
                $error("enable_pin: expected %0b, actual %0b", want.en, got.en);
                failures++;
            end
            if (got.hold !== want.hold)
            begin
                $error("hold_units: expected %0d, actual %0d", want.hold, got.hold);
                failures++;
            end
            if (got.fin !== want.fin)
            begin
                $error("last: expected %0b, actual %0b", want.fin, got.fin);
                failures++;
            end
        endfunction
    endclass

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic [CMD_W-1:0]  command    = CMD_INSTR;
    logic [BYTE_W-1:0] byte_value = '0;
    logic [LINE_W-1:0] line       = '0;
    logic [COL_W-1:0]  column     = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic [NIB_W-1:0]  data_nibble;
    logic              reg_select;
    logic              enable_pin;
    logic [HOLD_W-1:0] hold_units;
    logic              last;
    logic              cfg_we     = 1'b0;
    logic              cfg_index  = REG_STEP_HOLD;
    logic [CFG_W-1:0]  cfg_data   = '0;

    pin_step_ledger book = new();

    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    logic      pressure_on    = 1'b0;
    logic      pressure_done  = 1'b0;
    int        hold_left      = 0;
    int        quiet_cycles   = 0;
    pin_step_t seen;

    char_lcd_nibble_write_sequencer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .byte_value (byte_value),
        .line       (line),
        .column     (column),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_nibble(data_nibble),
        .reg_select (reg_select),
        .enable_pin (enable_pin),
        .hold_units (hold_units),
        .last       (last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Receiver: check each pin step, then pick next ready level
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen.nib  = data_nibble;
            seen.rs   = reg_select;
            seen.en   = enable_pin;
            seen.hold = hold_units;
            seen.fin  = last;
            book.check_step(seen);
        end
        // one long hold-off so the sequencer backs up into its input
        if (pressure_on && !pressure_done)
        begin
            hold_left     = HOLD_OFF_CYCLES;
            pressure_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic lcd_cmd_t make_cmd(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] val,
                                          logic [LINE_W-1:0] ln, logic [COL_W-1:0] col);
        lcd_cmd_t c;
        c.cmd = cmd;
        c.val = val;
        c.ln  = ln;
        c.col = col;
        return c;
    endfunction

    // Mostly byte commands, with an occasional init and spare code
    function automatic lcd_cmd_t random_command();
        lcd_cmd_t c;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 4)
            c.cmd = CMD_INIT;
        else if (pick < 10)
            c.cmd = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
        else
            c.cmd = CMD_W'($urandom_range(CMD_CHAR_AT, CMD_INSTR));
        c.val = BYTE_W'($urandom_range(2**BYTE_W - 1));
        c.ln  = LINE_W'($urandom_range(2**LINE_W - 1));
        c.col = COL_W'($urandom_range(2**COL_W - 1));
        return c;
    endfunction

    task automatic offer_command(lcd_cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= c.cmd;
        byte_value <= c.val;
        line       <= c.ln;
        column     <= c.col;
        do
            @(posedge clk);
        while (!in_ready);
        book.note_command(c);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        book.set_reg(idx, v);
    endtask

    task automatic program_holds(logic [CFG_W-1:0] step_v, logic [CFG_W-1:0] busy_v);
        write_reg(REG_STEP_HOLD, step_v);
        write_reg(REG_BUSY_HOLD, busy_v);
        cfg_we <= 1'b0;
    endtask

    // Stop offering and let every expected pin step drain out
    task automatic settle();
        in_valid <= 1'b0;
        while (book.expected_steps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(int n);
        lcd_cmd_t c;
        int       counted;
        counted = 0;
        while (counted < n)
        begin
            c = random_command();
            offer_command(c);
            if (c.cmd <= CMD_CHAR_AT)
                counted++;
        end
    endtask

    task automatic run_phase(int send_pct, int stall_pct,
                             logic [CFG_W-1:0] step_v, logic [CFG_W-1:0] busy_v);
        settle();
        program_holds(step_v, busy_v);
        send_idle_pct   = send_pct;
        recv_stall_pct <= stall_pct;
        run_random(ITEMS_PER_PHASE);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every command, field extremes, spare codes, reset holds
        offer_command(make_cmd(CMD_INIT,    8'h00, 2'd0, 6'd0));
        offer_command(make_cmd(CMD_INSTR,   8'h00, 2'd3, 6'd63));
        offer_command(make_cmd(CMD_INSTR,   8'hFF, 2'd0, 6'd0));
        offer_command(make_cmd(CMD_DATA,    8'h00, 2'd0, 6'd0));
        offer_command(make_cmd(CMD_DATA,    8'hFF, 2'd3, 6'd63));
        offer_command(make_cmd(CMD_DATA,    8'hA5, 2'd1, 6'd21));
        offer_command(make_cmd(CMD_SET_POS, 8'h00, 2'd0, 6'd0));
        offer_command(make_cmd(CMD_SET_POS, 8'hFF, 2'd1, 6'd63));
        offer_command(make_cmd(CMD_SET_POS, 8'h00, 2'd2, 6'd42));
        offer_command(make_cmd(CMD_SET_POS, 8'h00, 2'd3, 6'd63));
        offer_command(make_cmd(CMD_CHAR_AT, 8'h00, 2'd0, 6'd0));
        offer_command(make_cmd(CMD_CHAR_AT, 8'hFF, 2'd3, 6'd63));
        offer_command(make_cmd(CMD_CHAR_AT, 8'h5A, 2'd1, 6'd21));
        offer_command(make_cmd(CMD_CHAR_AT, 8'h3C, 2'd2, 6'd0));
        offer_command(make_cmd(CMD_SPARE_FIRST, 8'hFF, 2'd3, 6'd63));
        offer_command(make_cmd(CMD_SPARE_MID,   8'h81, 2'd2, 6'd33));
        offer_command(make_cmd(CMD_SPARE_LAST,  8'h7E, 2'd1, 6'd30));
        offer_command(make_cmd(CMD_DATA,    8'h42, 2'd0, 6'd0));
        offer_command(make_cmd(CMD_INIT,    8'hFF, 2'd3, 6'd63));

        // Random phases across idling modes and hold settings
        run_phase(68, 0, HOLD_MIN, HOLD_MIN);
        run_phase(0, 68, HOLD_MAX, HOLD_MAX);
        run_phase(17, 17, CFG_W'($urandom_range(2**CFG_W - 1)),
                  CFG_W'($urandom_range(2**CFG_W - 1)));

        // Back-pressure: receiver stalls long while commands keep coming
        settle();
        program_holds(16'd1, HOLD_MAX);
        send_idle_pct   = 0;
        recv_stall_pct <= 0;
        pressure_on    <= 1'b1;
        run_random(ITEMS_PER_PHASE);

        run_phase(0, 0, HOLD_MAX, HOLD_MIN);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.failures == 0 && book.expected_steps.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[char_lcd_nibble_write_sequencer.f]
sv/clcd_pkg.sv
sv/clcd_seq.sv
sv/clcd_pin.sv
sv/char_lcd_nibble_write_sequencer.sv
bench/testbench.sv
